// ----- rtl/lti_pkg.sv -----
// Shared types and constants of the Lagrange table interpolator.
package lti_pkg;

  // Q16.16 data and derived widths
  localparam int unsigned DataW    = 32;
  localparam int unsigned DiffW    = DataW + 1;          // |a - b| of two Q16.16 values
  localparam int unsigned MagW     = 61;                 // term magnitude, held at 2^60
  localparam int unsigned ProdW    = MagW + DiffW;       // magnitude times difference
  localparam int unsigned MagLoW   = 32;                 // low multiplier slice
  localparam int unsigned DivSteps = ProdW / 2;          // two quotient bits per cycle
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);
  localparam int unsigned LenW     = 7;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned PtW      = 3;                  // stencil point counter
  localparam int unsigned SumW     = 64;

  localparam logic [PtW-1:0]  StencilPoints = PtW'(5);
  localparam logic [PtW-1:0]  EdgePoints    = PtW'(2);
  localparam logic [LenW-1:0] LenReset      = LenW'(64);
  localparam logic            ModeWrite     = 1'b0;
  localparam logic            ModeQuery     = 1'b1;

  // Input transaction
  typedef struct packed {
    logic                    mode;
    logic [IdxW-1:0]         entry_index;
    logic signed [DataW-1:0] sample_abscissa;
    logic signed [DataW-1:0] sample_ordinate;
    logic [IdxW-1:0]         channel_index;
    logic signed [DataW-1:0] query_point;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic signed [DataW-1:0] interpolated_value;
    logic                    duplicate_abscissa;
    logic                    saturated;
  } out_t;

  // Request to the multiply-divide unit: floor(mag * num / den)
  typedef struct packed {
    logic             start;
    logic [MagW-1:0]  mag;
    logic [DiffW-1:0] num;
    logic [DiffW-1:0] den;
  } scale_req_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] mag;
    logic            clip;
  } scale_rsp_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL0,
    SC_MUL1,
    SC_DIV,
    SC_DONE
  } scale_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TERM,
    S_TERM_D,
    S_FACT,
    S_DIFF,
    S_SCALE,
    S_ACC,
    S_DONE
  } seq_state_e;

endpackage

// ----- rtl/lti_table_mem.sv -----
// Sample point table: one write port, one read port, registered read data.
module lti_table_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 64
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];

  // The user keeps writes only while idle and reads only while busy; this module does not enforce it, so no bypass
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/lti_scale_unit.sv -----
// Multiply-divide unit: floor(mag * num / den), held at 2^60 with a clip flag.
module lti_scale_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lti_pkg::scale_req_t     req_i,
  output lti_pkg::scale_rsp_t     rsp_o
);

  localparam int unsigned ProdW = lti_pkg::ProdW;
  localparam int unsigned DiffW = lti_pkg::DiffW;
  localparam int unsigned MagW  = lti_pkg::MagW;
  localparam int unsigned LoW   = lti_pkg::MagLoW;
  localparam int unsigned HiW   = MagW - LoW;

  lti_pkg::scale_state_e state_q, state_d;

  logic [MagW-1:0]                 a_q, a_d;
  logic [DiffW-1:0]                b_q, b_d, c_q, c_d;
  logic [ProdW-1:0]                prod_q, prod_d;   // product, then quotient
  logic [DiffW-1:0]                rem_q, rem_d;
  logic [lti_pkg::DivCntW-1:0]     cnt_q, cnt_d;

  logic [LoW+DiffW-1:0]            mul_lo;
  logic [HiW+DiffW-1:0]            mul_hi;
  logic [DiffW:0]                  r1, r2, s1, s2;
  logic                            q1, q2;
  logic [DiffW-1:0]                rem1;
  logic                            over;

  // Multiplier slices, one per cycle
  assign mul_lo = LoW'(a_q[LoW-1:0]) * b_q;
  assign mul_hi = a_q[MagW-1:LoW] * b_q;

  // Two restoring division steps per cycle
  always_comb begin
    r1   = {rem_q, prod_q[ProdW-1]};
    s1   = r1 - {1'b0, c_q};
    q1   = (r1 >= {1'b0, c_q});
    rem1 = q1 ? s1[DiffW-1:0] : r1[DiffW-1:0];
    r2   = {rem1, prod_q[ProdW-2]};
    s2   = r2 - {1'b0, c_q};
    q2   = (r2 >= {1'b0, c_q});
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lti_pkg::SC_IDLE: if (req_i.start) state_d = lti_pkg::SC_MUL0;
      lti_pkg::SC_MUL0: state_d = lti_pkg::SC_MUL1;
      lti_pkg::SC_MUL1: state_d = lti_pkg::SC_DIV;
      lti_pkg::SC_DIV: begin
        if (cnt_q == lti_pkg::DivCntW'(lti_pkg::DivSteps - 1)) state_d = lti_pkg::SC_DONE;
      end
      lti_pkg::SC_DONE: state_d = lti_pkg::SC_IDLE;
      default:          state_d = lti_pkg::SC_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    unique case (state_q)
      lti_pkg::SC_IDLE: begin
        a_d = req_i.mag;
        b_d = req_i.num;
        c_d = req_i.den;
      end
      lti_pkg::SC_MUL0: prod_d = ProdW'(mul_lo);
      lti_pkg::SC_MUL1: begin
        prod_d = prod_q + {mul_hi, {LoW{1'b0}}};
        rem_d  = '0;
        cnt_d  = '0;
      end
      lti_pkg::SC_DIV: begin
        rem_d  = q2 ? s2[DiffW-1:0] : r2[DiffW-1:0];
        prod_d = {prod_q[ProdW-3:0], q1, q2};
        cnt_d  = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Quotient above 2^60 is held there
  assign over = (|prod_q[ProdW-1:MagW]) || (prod_q[MagW-1] && (|prod_q[MagW-2:0]));

  // Outputs
  always_comb begin
    rsp_o.done = (state_q == lti_pkg::SC_DONE);
    rsp_o.clip = over;
    rsp_o.mag  = over ? {1'b1, {(MagW-1){1'b0}}} : prod_q[MagW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lti_pkg::SC_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

endmodule

// ----- rtl/lagrange_table_interpolator.sv -----
// Top level: table of Q16.16 sample points and Lagrange interpolation sequencer.
//
// A write transaction (mode 0) stores one abscissa/ordinate pair, and busy
// stays low. A query transaction (mode 1) raises busy until its result has
// been shown for one cycle with result_valid_o; the receiver cannot stall,
// so the result must be captured in that cycle. With n stencil points
// (2 at the table edges, 5 otherwise), the shared multiply-divide unit runs
// each of the n*(n-1) factors whose abscissae differ through a split
// multiply and a radix-4 restoring divider, with the table memory read once
// per term and once per factor.
module lagrange_table_interpolator #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  lti_pkg::in_t             cmd_i,
  output logic                     result_valid_o,
  output lti_pkg::out_t            result_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [lti_pkg::LenW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned DataW = lti_pkg::DataW;
  localparam int unsigned DiffW = lti_pkg::DiffW;
  localparam int unsigned MagW  = lti_pkg::MagW;
  localparam int unsigned SumW  = lti_pkg::SumW;
  localparam int unsigned PtW   = lti_pkg::PtW;

  lti_pkg::seq_state_e state_q, state_d;

  logic [lti_pkg::LenW-1:0]  table_length_q;
  logic [AddrW-1:0]          base_q, base_d;
  logic                      down_q, down_d;
  logic [PtW-1:0]            n_q, n_d, i_q, i_d, j_q, j_d;
  logic signed [DataW-1:0]   qpt_q, qpt_d, xi_q, xi_d;
  logic [MagW-1:0]           m_q, m_d;
  logic                      neg_q, neg_d, dup_q, dup_d, sat_q, sat_d;
  logic signed [SumW-1:0]    sum_q, sum_d;
  logic [DiffW-1:0]          dm_q, dm_d, em_q, em_d;

  logic                      mem_we;
  logic [AddrW-1:0]          raddr;
  logic [2*DataW-1:0]        rdata;
  logic signed [DataW-1:0]   rd_x, rd_y;
  logic [PtW-1:0]            k;
  logic                      wr_acc, qry_acc;
  int                        len_c, ch_c, base_c;
  logic                      down_c;
  logic [PtW-1:0]            n_c;
  logic signed [DiffW-1:0]   dq, dx;
  logic [PtW-1:0]            j_next;
  logic                      last_fact;
  logic signed [SumW-1:0]    term;
  logic                      hi_clip, lo_clip;

  lti_pkg::scale_req_t       sreq;
  lti_pkg::scale_rsp_t       srsp;

  assign busy    = (state_q != lti_pkg::S_IDLE);
  assign wr_acc  = start && !busy && (cmd_i.mode == lti_pkg::ModeWrite);
  assign qry_acc = start && !busy && (cmd_i.mode == lti_pkg::ModeQuery);
  assign mem_we  = wr_acc && (int'(cmd_i.entry_index) < int'(TABLE_DEPTH));

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= lti_pkg::LenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      table_length_q <= cfg_data_i;
    end
  end

  // Stencil choice from channel and clamped length
  always_comb begin
    len_c = int'(table_length_q);
    if (len_c < 2) len_c = 2;
    if (len_c > int'(TABLE_DEPTH)) len_c = int'(TABLE_DEPTH);
    ch_c = int'(cmd_i.channel_index);
    if (ch_c < 2) begin
      base_c = 0;
      down_c = 1'b0;
      n_c    = lti_pkg::EdgePoints;
    end else if (ch_c > len_c - 3) begin
      base_c = len_c - 1;
      down_c = 1'b1;
      n_c    = lti_pkg::EdgePoints;
    end else begin
      base_c = ch_c - 2;
      down_c = 1'b0;
      n_c    = lti_pkg::StencilPoints;
    end
  end

  // Table read address: factor point while fetching a factor, else term point
  assign k     = (state_q == lti_pkg::S_FACT) ? j_q : i_q;
  assign raddr = down_q ? (base_q - AddrW'(k)) : (base_q + AddrW'(k));

  lti_table_mem #(
    .Depth (TABLE_DEPTH),
    .AddrW (AddrW),
    .DataW (2 * DataW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(cmd_i.entry_index)),
    .wdata_i ({cmd_i.sample_abscissa, cmd_i.sample_ordinate}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_x = rdata[2*DataW-1:DataW];
  assign rd_y = rdata[DataW-1:0];

  // Differences of the factor now read from the table
  assign dq = DiffW'(qpt_q) - DiffW'(rd_x);
  assign dx = DiffW'(xi_q) - DiffW'(rd_x);

  // Next factor index, skipping the term's own point
  always_comb begin
    j_next = j_q + 1'b1;
    if (j_next == i_q) j_next = j_next + 1'b1;
    last_fact = (j_next >= n_q);
  end

  assign term = neg_q ? -SumW'(m_q) : SumW'(m_q);

  lti_scale_unit u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sreq),
    .rsp_o  (srsp)
  );

  always_comb begin
    sreq.start = 1'b0;
    sreq.mag   = m_q;
    sreq.num   = dm_q;
    sreq.den   = em_q;
    if (state_q == lti_pkg::S_DIFF) begin
      sreq.start = (dx != '0);
      sreq.mag   = m_q;
      sreq.num   = dq[DiffW-1] ? DiffW'(-dq) : DiffW'(dq);
      sreq.den   = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lti_pkg::S_IDLE:   if (qry_acc) state_d = lti_pkg::S_TERM;
      lti_pkg::S_TERM:   state_d = lti_pkg::S_TERM_D;
      lti_pkg::S_TERM_D: state_d = lti_pkg::S_FACT;
      lti_pkg::S_FACT:   state_d = lti_pkg::S_DIFF;
      lti_pkg::S_DIFF: begin
        if (dx != '0)     state_d = lti_pkg::S_SCALE;
        else if (last_fact) state_d = lti_pkg::S_ACC;
        else              state_d = lti_pkg::S_FACT;
      end
      lti_pkg::S_SCALE: begin
        if (srsp.done) state_d = last_fact ? lti_pkg::S_ACC : lti_pkg::S_FACT;
      end
      lti_pkg::S_ACC: begin
        state_d = (i_q + 1'b1 == n_q) ? lti_pkg::S_DONE : lti_pkg::S_TERM;
      end
      lti_pkg::S_DONE:   state_d = lti_pkg::S_IDLE;
      default:           state_d = lti_pkg::S_IDLE;
    endcase
  end

  // Sequencer register updates
  always_comb begin
    base_d = base_q;
    down_d = down_q;
    n_d    = n_q;
    i_d    = i_q;
    j_d    = j_q;
    qpt_d  = qpt_q;
    xi_d   = xi_q;
    m_d    = m_q;
    neg_d  = neg_q;
    dup_d  = dup_q;
    sat_d  = sat_q;
    sum_d  = sum_q;
    dm_d   = dm_q;
    em_d   = em_q;
    unique case (state_q)
      lti_pkg::S_IDLE: begin
        if (qry_acc) begin
          base_d = AddrW'(base_c);
          down_d = down_c;
          n_d    = n_c;
          qpt_d  = cmd_i.query_point;
          i_d    = '0;
          dup_d  = 1'b0;
          sat_d  = 1'b0;
          sum_d  = '0;
        end
      end
      lti_pkg::S_TERM_D: begin
        xi_d  = rd_x;
        neg_d = rd_y[DataW-1];
        m_d   = MagW'(rd_y[DataW-1] ? -DiffW'(rd_y) : DiffW'(rd_y));
        j_d   = (i_q == '0) ? PtW'(1) : '0;
      end
      lti_pkg::S_DIFF: begin
        dm_d  = sreq.num;
        em_d  = sreq.den;
        neg_d = neg_q ^ (dq[DiffW-1] ^ dx[DiffW-1]);
        if (dx == '0) begin
          dup_d = 1'b1;
          j_d   = j_next;
        end
      end
      lti_pkg::S_SCALE: begin
        if (srsp.done) begin
          m_d   = srsp.mag;
          sat_d = sat_q | srsp.clip;
          j_d   = j_next;
        end
      end
      lti_pkg::S_ACC: begin
        sum_d = sum_q + term;
        i_d   = i_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lti_pkg::S_IDLE;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      down_q  <= 1'b0;
      dup_q   <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      down_q  <= down_d;
      dup_q   <= dup_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    qpt_q  <= qpt_d;
    xi_q   <= xi_d;
    m_q    <= m_d;
    neg_q  <= neg_d;
    sum_q  <= sum_d;
    dm_q   <= dm_d;
    em_q   <= em_d;
  end

  // Result: clip the sum to Q16.16, zero on equal abscissae
  assign hi_clip = (sum_q > SumW'(64'sh0000_0000_7FFF_FFFF));
  assign lo_clip = (sum_q < -SumW'(64'sh0000_0000_8000_0000));

  always_comb begin
    result_valid_o = (state_q == lti_pkg::S_DONE);
    result_o.duplicate_abscissa = dup_q;
    if (dup_q) begin
      result_o.interpolated_value = '0;
      result_o.saturated          = 1'b0;
    end else if (hi_clip) begin
      result_o.interpolated_value = {1'b0, {(DataW-1){1'b1}}};
      result_o.saturated          = 1'b1;
    end else if (lo_clip) begin
      result_o.interpolated_value = {1'b1, {(DataW-1){1'b0}}};
      result_o.saturated          = 1'b1;
    end else begin
      result_o.interpolated_value = sum_q[DataW-1:0];
      result_o.saturated          = sat_q;
    end
  end

endmodule

// ----- rtl/lti_checker.sv -----
// Port-level checks of the interpolator, bound to the top level.
module lti_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input lti_pkg::in_t  cmd_i,
  input logic          result_valid_o,
  input lti_pkg::out_t result_o
);

  // A result only appears while a query transaction is in flight
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside a query");

  // The strobe lasts one cycle and ends the query
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy) else $error("result repeated");

  // Equal abscissae give a zero, unsaturated value
  a_dup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.duplicate_abscissa |->
      result_o.interpolated_value == '0 && !result_o.saturated)
    else $error("duplicate result not zero");

  // A table write completes at once, a query occupies the block
  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.mode == lti_pkg::ModeWrite |=> !busy)
    else $error("write left block busy");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.mode == lti_pkg::ModeQuery |=> busy && !result_valid_o)
    else $error("query not taken");

endmodule

bind lagrange_table_interpolator lti_checker u_lti_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
